// File: rtl/core/fsa_pkg.sv
package fsa_pkg;

    // fixed field widths
    localparam int SLOT_W       = 10;
    localparam int FILL_W       = 11;
    localparam int STATUS_W     = 2;
    localparam int POOL_LIMIT_W = 11;

    // defaults
    localparam int DEF_SLOTS = 1024;
    localparam logic [POOL_LIMIT_W-1:0] POOL_LIMIT_RST = 11'd1024;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // request word
    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot_index;
    } t_fsa_req;

    // result word
    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_count;
    } t_fsa_rsp;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_fsa_state;

    // controller to datapath
    typedef struct packed {
        logic clr_we;
        logic accept;
        logic exec;
    } t_fsa_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_fsa_stat;

endpackage

// File: rtl/core/fsa_ram.sv
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/fsa_ctrl.sv
module fsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fsa_pkg::t_fsa_stat i_stat,
    output fsa_pkg::t_fsa_cmd o_cmd,
    output logic              o_busy
);

    import fsa_pkg::*;

    t_fsa_state r_state;
    t_fsa_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // an accepted word always executes in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.exec)
        else $error("accepted word did not execute");

    // execute lasts one cycle and frees the block again
    a_exec_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_busy)
        else $error("block stayed busy after execute");

endmodule

// File: rtl/core/fsa_datapath.sv
module fsa_datapath #(
    parameter int SLOTS = fsa_pkg::DEF_SLOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fsa_pkg::t_fsa_cmd                   i_cmd,
    output fsa_pkg::t_fsa_stat                  o_stat,
    input  fsa_pkg::t_fsa_req                   i_req,
    input  logic                                i_cfg_we,
    input  logic [fsa_pkg::POOL_LIMIT_W-1:0]    i_cfg_wdata,
    output fsa_pkg::t_fsa_rsp                   o_rsp,
    output logic                                o_done
);

    import fsa_pkg::*;

    // address, head/count and link widths
    localparam int AW   = $clog2(SLOTS);
    localparam int HW   = $clog2(SLOTS + 1);
    localparam int LW   = $clog2(SLOTS + 2);
    localparam int CMPW = (HW > POOL_LIMIT_W) ? HW : POOL_LIMIT_W;
    localparam int SW   = (HW > SLOT_W) ? HW : SLOT_W;

    logic [HW-1:0]           r_head;
    logic [HW-1:0]           n_head;
    logic [HW-1:0]           r_count;
    logic [HW-1:0]           n_count;
    logic [POOL_LIMIT_W-1:0] r_limit;
    logic [AW-1:0]           r_clr_addr;
    t_fsa_req                r_req;
    t_fsa_rsp                r_rsp;
    t_fsa_rsp                n_rsp;
    logic                    r_done;

    logic                    alloc_full;
    logic                    free_empty;
    logic                    slot_ok;
    logic                    free_wr;
    logic [LW-1:0]           rd_link;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [LW-1:0]           ram_wdata;

    // pool limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= POOL_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // clearing sweep over the link memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(SLOTS - 1));

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
    end

    // decisions and next values
    always_comb begin
        alloc_full = (CMPW'(r_count) >= CMPW'(r_limit))
                  || (r_count >= HW'(SLOTS))
                  || (r_head >= HW'(SLOTS));
        free_empty = (r_count == '0);
        slot_ok    = (SW'(r_req.slot_index) < SW'(SLOTS));
        free_wr    = 1'b0;
        n_head     = r_head;
        n_count    = r_count;
        n_rsp.granted_slot = '0;
        n_rsp.status       = ST_OK;
        if (r_req.action == ACT_ALLOC) begin
            if (alloc_full) begin
                n_rsp.status = ST_FULL;
            end else begin
                n_rsp.granted_slot = SLOT_W'(r_head);
                if (rd_link == '0) begin
                    n_head = r_head + HW'(1);
                end else begin
                    n_head = HW'(rd_link - LW'(1));
                end
                n_count = r_count + HW'(1);
            end
        end else begin
            if (free_empty) begin
                n_rsp.status = ST_EMPTY;
            end else if (slot_ok) begin
                free_wr = 1'b1;
                n_head  = HW'(r_req.slot_index);
                n_count = r_count - HW'(1);
            end
        end
        n_rsp.fill_count = FILL_W'(n_count);
    end

    // head and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
        end
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_done;

    // link memory write select: clearing sweep or free push
    assign ram_we    = i_cmd.clr_we || (i_cmd.exec && free_wr);
    assign ram_waddr = i_cmd.clr_we ? r_clr_addr : AW'(r_req.slot_index);
    assign ram_wdata = i_cmd.clr_we ? '0 : (LW'(r_head) + LW'(1));

    fsa_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (AW'(r_head)),
        .o_rd_data (rd_link)
    );

    // head stays within 0..SLOTS
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= HW'(SLOTS))
        else $error("free head beyond pool");

    // fill count stays within 0..SLOTS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HW'(SLOTS))
        else $error("fill count beyond pool");

    // state only moves on an execute cycle
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_count) && $stable(r_head)))
        else $error("allocator state changed outside execute");

    // one strobe per execute
    a_done_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_done)
        else $error("missing result strobe");

endmodule

// File: rtl/core/free_list_slot_allocator_core.sv
// Slot allocator over a fixed pool, kept as a linked free list in a link
// memory of SLOTS entries. A request (allocate or free) is taken when start
// is high and busy is low; its result word is registered onto o_rsp at the
// end of the execute cycle, marked by o_done for exactly one cycle, and the
// receiver cannot stall it. The accept cycle reads the head's link from the
// memory, the next cycle updates head and fill count and writes a freed
// slot's link; no new request is taken then, but busy drops again while the
// result strobe is up. After reset the block is busy while the link memory
// is swept to zero; the pool limit may be written at any idle time,
// including during that sweep.
module free_list_slot_allocator_core #(
    parameter int SLOTS = fsa_pkg::DEF_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fsa_pkg::t_fsa_req                i_req,
    output fsa_pkg::t_fsa_rsp                o_rsp,
    output logic                             o_done,
    input  logic                             i_cfg_we,
    input  logic [fsa_pkg::POOL_LIMIT_W-1:0] i_cfg_wdata
);

    import fsa_pkg::*;

    t_fsa_cmd  cmd;
    t_fsa_stat stat;

    // sequencer
    fsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // head, count and link memory
    fsa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp),
        .o_done      (o_done)
    );

endmodule

// File: dv/tb_free_list_slot_allocator_core.sv
`timescale 1ns / 1ps

module tb_free_list_slot_allocator_core;

    import fsa_pkg::*;

    localparam int NSLOTS = DEF_SLOTS;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    t_fsa_req                i_req = '0;
    t_fsa_rsp                o_rsp;
    logic                    o_done;
    logic                    i_cfg_we = 1'b0;
    logic [POOL_LIMIT_W-1:0] i_cfg_wdata = '0;

    // shadow of the allocator state
    logic [FILL_W-1:0]       link_mem [NSLOTS];
    logic [FILL_W-1:0]       head_ptr;
    logic [FILL_W-1:0]       used_cnt;
    logic [POOL_LIMIT_W-1:0] limit_reg;

    t_fsa_req    req_q[$];
    t_fsa_rsp    due_rsp_q[$];
    logic [SLOT_W-1:0] held_slots[$];
    int          n_left = 0;
    int          n_acc = 0;
    int          n_err = 0;
    bit          took = 1'b0;
    bit          drain = 1'b0;

    free_list_slot_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_done      (o_done),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one line per mismatch
    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        n_err++;
    endtask

    // next result word of the allocator, updates the shadow state
    function automatic t_fsa_rsp grant_request(input t_fsa_req r);
        t_fsa_rsp res;
        logic [FILL_W-1:0] nxt;
        res = '0;
        res.status = ST_OK;
        if (r.action == ACT_ALLOC) begin
            if (used_cnt >= limit_reg || used_cnt >= NSLOTS || head_ptr >= NSLOTS) begin
                res.status = ST_FULL;
            end else begin
                res.granted_slot = head_ptr[SLOT_W-1:0];
                // zero link means the slot right after this one
                nxt = (link_mem[head_ptr] == '0) ? head_ptr + 1'b1
                                                 : link_mem[head_ptr] - 1'b1;
                head_ptr = (nxt > NSLOTS) ? FILL_W'(NSLOTS) : nxt;
                used_cnt = used_cnt + 1'b1;
            end
        end else begin
            if (used_cnt == '0) begin
                res.status = ST_EMPTY;
            end else if (r.slot_index < NSLOTS) begin
                link_mem[r.slot_index] = head_ptr + 1'b1;
                head_ptr = FILL_W'(r.slot_index);
                used_cnt = used_cnt - 1'b1;
            end
        end
        res.fill_count = used_cnt;
        return res;
    endfunction

    // result checker and request predictor, sampled at the rising edge
    always @(posedge i_clk) begin : rsp_monitor
        t_fsa_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOTS; i++) begin
                link_mem[i] = '0;
            end
            head_ptr  = '0;
            used_cnt  = '0;
            limit_reg = POOL_LIMIT_RST;
            took      = 1'b0;
        end else begin
            // compare the result word with the oldest prediction
            if (o_done) begin
                if (due_rsp_q.size() == 0) begin
                    flag_mismatch($sformatf("result word with none due: %p", o_rsp));
                end else begin
                    want = due_rsp_q.pop_front();
                    if (o_rsp.granted_slot !== want.granted_slot)
                        flag_mismatch($sformatf("granted_slot %0d, want %0d",
                                                o_rsp.granted_slot, want.granted_slot));
                    if (o_rsp.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                o_rsp.status, want.status));
                    if (o_rsp.fill_count !== want.fill_count)
                        flag_mismatch($sformatf("fill_count %0d, want %0d",
                                                o_rsp.fill_count, want.fill_count));
                end
            end
            // register write
            if (i_cfg_we) begin
                limit_reg = i_cfg_wdata;
            end
            // accepted request word
            if (start && !busy) begin
                want = grant_request(i_req);
                if (i_req.action == ACT_ALLOC && want.status == ST_OK) begin
                    held_slots.push_back(want.granted_slot);
                end
                due_rsp_q.push_back(want);
                took = 1'b1;
                n_left--;
                n_acc++;
            end
        end
    end

    // request driver, next word at the falling edge
    always @(negedge i_clk) begin : req_driver
        int gap_pct;
        gap_pct = (n_acc < 250) ? 27 : (n_acc < 500) ? 59 : 0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            took = 1'b0;
            if (drain && due_rsp_q.size() == 0) begin
                drain = 1'b0;
            end
            if (drain || req_q.size() == 0 || $urandom_range(99) < gap_pct) begin
                start <= 1'b0;
            end else if ($urandom_range(63) == 0) begin
                // hold off until every result is back
                drain = 1'b1;
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_req <= req_q.pop_front();
            end
        end
    end

    // push one request word, keep the queue short so frees see fresh grants
    task automatic queue_item(input logic act, input logic [SLOT_W-1:0] slot);
        t_fsa_req r;
        while (req_q.size() >= 4) @(negedge i_clk);
        r.action     = act;
        r.slot_index = slot;
        req_q.push_back(r);
        n_left++;
    endtask

    task automatic wait_idle();
        while (n_left != 0 || due_rsp_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [POOL_LIMIT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random phase: allocates at alloc_pct, else mostly frees of slots held, some noise frees
    task automatic run_phase(input logic [POOL_LIMIT_W-1:0] lim, input int alloc_pct,
                             input int count);
        int k;
        logic [SLOT_W-1:0] s;
        wait_idle();
        write_limit(lim);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < alloc_pct) begin
                queue_item(ACT_ALLOC, SLOT_W'($urandom_range(NSLOTS - 1)));
            end else if (held_slots.size() == 0 || $urandom_range(9) == 0) begin
                queue_item(ACT_FREE, SLOT_W'($urandom_range(NSLOTS - 1)));
            end else begin
                k = $urandom_range(held_slots.size() - 1);
                s = held_slots[k];
                held_slots.delete(k);
                queue_item(ACT_FREE, s);
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: limit of three, empty frees, full, double free
        write_limit(11'd3);
        queue_item(ACT_FREE, 10'd0);
        queue_item(ACT_FREE, 10'd1023);
        queue_item(ACT_ALLOC, 10'd1023);
        queue_item(ACT_ALLOC, 10'h2AA);
        queue_item(ACT_ALLOC, 10'h155);
        queue_item(ACT_ALLOC, 10'd0);
        queue_item(ACT_FREE, 10'd1);
        queue_item(ACT_FREE, 10'd1);
        queue_item(ACT_ALLOC, 10'd0);
        queue_item(ACT_ALLOC, 10'd0);
        queue_item(ACT_ALLOC, 10'd0);
        queue_item(ACT_FREE, 10'h2AA);
        queue_item(ACT_FREE, 10'h155);
        queue_item(ACT_FREE, 10'd1023);

        // directed: limit of zero, every allocate full
        wait_idle();
        write_limit(11'd0);
        queue_item(ACT_ALLOC, 10'd0);
        queue_item(ACT_FREE, 10'd0);
        queue_item(ACT_ALLOC, 10'd1023);

        // random phases across limits
        run_phase(11'd1, 50, 40);
        run_phase(11'd7, 55, 80);
        run_phase(11'd1024, 50, 100);
        run_phase(11'd100, 70, 160);
        run_phase(11'd2, 45, 50);
        // allocate heavy, push the fill count up
        run_phase(11'd1024, 80, 200);
        run_phase(11'd1024, 25, 100);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (n_err == 0 && due_rsp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run time limit
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/core/fsa_pkg.sv
rtl/core/fsa_ram.sv
rtl/core/fsa_ctrl.sv
rtl/core/fsa_datapath.sv
rtl/core/free_list_slot_allocator_core.sv
dv/tb_free_list_slot_allocator_core.sv
